/* design/smpq_pkg.sv */
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int PRIO_BITS_DEF   = 8;

  localparam int ID_W        = 16;
  localparam int STAMP_W     = 32;
  localparam int IN_PRIO_W   = 8;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_POP     = 2'd1,
    KIND_UPGRADE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK              = 3'd0,
    STATUS_EMPTY           = 3'd1,
    STATUS_NOT_FOUND       = 3'd2,
    STATUS_NOT_MORE_URGENT = 3'd3,
    STATUS_FULL            = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN_A,
    S_WRITE,
    S_SCAN_B,
    S_CLEAR,
    S_DONE
  } state_t;

endpackage

/* design/smpq_ram.sv */
`timescale 1ns / 1ps

module smpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* design/smpq_cmp.sv */
`timescale 1ns / 1ps

module smpq_cmp import smpq_pkg::*; #(
  parameter int PRIO_W = PRIO_BITS_DEF
) (
  input  logic [PRIO_W-1:0]  a_prio,
  input  logic [STAMP_W-1:0] a_stamp,
  input  logic [PRIO_W-1:0]  b_prio,
  input  logic [STAMP_W-1:0] b_stamp,
  output logic               a_first
);

  // smaller priority wins, older stamp breaks ties
  assign a_first = (a_prio < b_prio) || ((a_prio == b_prio) && (a_stamp < b_stamp));

endmodule

/* design/stable_min_priority_queue_unit.sv */
`timescale 1ns / 1ps
// each operation runs to completion before the next is accepted: in_tready is high only in idle
// an operation makes two full passes (clear: one) over the single-port slot memory through the one
//   shared compare unit before its result word is loaded
// reset: synchronous active-low; afterwards a clearing pass invalidates
//   every slot, in_tready stays low until it ends

module stable_min_priority_queue_unit import smpq_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int PRIO_BITS   = PRIO_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // entry_id[15:0], prio_value[23:16]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // popped_id[15:0], front_id[31:16], front_prio[39:32],
                                  // is_empty[40], entry_count[47:41]
  output logic [2:0]  out_tuser   // status[2:0]
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int WORD_W = 1 + STAMP_W + PRIO_BITS + ID_W;
  localparam logic [AW-1:0] LAST_IDX   = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  // sequencer
  state_t state_r, state_nxt;

  // scan address generation and read pipeline
  logic [AW-1:0] addr_r;
  logic          issue_done_r;
  logic          rd_pend_r;
  logic [AW-1:0] rd_idx_r;

  // current operation
  kind_t                kind_r;
  logic [ID_W-1:0]      id_r;
  logic [PRIO_BITS-1:0] prio_r;

  // running best and first free slot
  logic                 best_found_r;
  logic [AW-1:0]        best_idx_r;
  logic [ID_W-1:0]      best_id_r;
  logic [PRIO_BITS-1:0] best_prio_r;
  logic [STAMP_W-1:0]   best_stamp_r;
  logic                 free_found_r;
  logic [AW-1:0]        free_idx_r;

  // queue bookkeeping
  logic [STAMP_W-1:0] stamp_ctr_r;
  logic [CW-1:0]      count_r;
  status_t            status_r;
  logic [ID_W-1:0]    popped_r;

  // result register
  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;
  logic [2:0]  out_tuser_r;

  // slot memory port
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // read word fields
  logic                 rd_valid;
  logic [ID_W-1:0]      rd_id;
  logic [PRIO_BITS-1:0] rd_prio;
  logic [STAMP_W-1:0]   rd_stamp;

  // shared compare unit operands
  logic [PRIO_BITS-1:0] cmp_a_prio;
  logic [STAMP_W-1:0]   cmp_a_stamp;
  logic                 a_first;

  logic    in_fire;
  logic    out_free;
  logic    scan_last;
  logic    sweep_last;
  logic    cand_ok;
  logic    take_best;
  logic    take_free;
  status_t wr_status;
  logic    ins_ok;
  logic    pop_ok;

  assign rd_id    = ram_rdata[ID_W-1:0];
  assign rd_prio  = ram_rdata[ID_W +: PRIO_BITS];
  assign rd_stamp = ram_rdata[ID_W+PRIO_BITS +: STAMP_W];
  assign rd_valid = ram_rdata[WORD_W-1];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign scan_last  = rd_pend_r && (rd_idx_r == LAST_IDX);
  assign sweep_last = (addr_r == LAST_IDX);

  // candidate counts for pop and the front scan when valid, for upgrade only on an id match
  assign cand_ok   = rd_pend_r && rd_valid &&
                     ((state_r == S_SCAN_B) || (kind_r != KIND_UPGRADE) || (rd_id == id_r));
  assign take_best = cand_ok && (!best_found_r || a_first);
  assign take_free = rd_pend_r && !rd_valid && !free_found_r;

  // in the write step the unit checks new priority against the found entry;
  // equal stamps make it a strict priority compare
  always_comb begin
    if (state_r == S_WRITE) begin
      cmp_a_prio  = prio_r;
      cmp_a_stamp = best_stamp_r;
    end else begin
      cmp_a_prio  = rd_prio;
      cmp_a_stamp = rd_stamp;
    end
  end

  smpq_cmp #(
    .PRIO_W (PRIO_BITS)
  ) u_cmp (
    .a_prio  (cmp_a_prio),
    .a_stamp (cmp_a_stamp),
    .b_prio  (best_prio_r),
    .b_stamp (best_stamp_r),
    .a_first (a_first)
  );

  smpq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (kind_t'(in_tuser) == KIND_CLEAR) state_nxt = S_CLEAR;
          else                                  state_nxt = S_SCAN_A;
        end
      end
      S_SCAN_A: begin
        if (scan_last) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        state_nxt = S_SCAN_B;
      end
      S_SCAN_B: begin
        if (scan_last) state_nxt = S_DONE;
      end
      S_CLEAR: begin
        if (sweep_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // memory control and write decision
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_r;
    ram_wdata = {1'b0, best_stamp_r, best_prio_r, best_id_r};
    wr_status = STATUS_OK;
    ins_ok    = 1'b0;
    pop_ok    = 1'b0;
    unique case (state_r)
      S_INIT, S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_WRITE: begin
        unique case (kind_r)
          KIND_INSERT: begin
            if (free_found_r) begin
              ins_ok    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = free_idx_r;
              ram_wdata = {1'b1, stamp_ctr_r + 32'd1, prio_r, id_r};
            end else begin
              wr_status = STATUS_FULL;
            end
          end
          KIND_POP: begin
            if (best_found_r) begin
              pop_ok   = 1'b1;
              ram_we   = 1'b1;
              ram_addr = best_idx_r;
            end else begin
              wr_status = STATUS_EMPTY;
            end
          end
          KIND_UPGRADE: begin
            if (!best_found_r) begin
              wr_status = STATUS_NOT_FOUND;
            end else if (!a_first) begin
              wr_status = STATUS_NOT_MORE_URGENT;
            end else begin
              ram_we    = 1'b1;
              ram_addr  = best_idx_r;
              ram_wdata = {1'b1, best_stamp_r, prio_r, best_id_r};
            end
          end
          default: wr_status = STATUS_OK;
        endcase
      end
      default: ram_we = 1'b0;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      addr_r       <= '0;
      issue_done_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      best_found_r <= 1'b0;
      free_found_r <= 1'b0;
      stamp_ctr_r  <= '0;
      count_r      <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_INIT: begin
          addr_r <= sweep_last ? '0 : addr_r + AW'(1);
        end
        S_IDLE: begin
          if (in_fire) begin
            kind_r       <= kind_t'(in_tuser);
            id_r         <= in_tdata[15:0];
            prio_r       <= PRIO_BITS'(in_tdata[23:16]);
            addr_r       <= '0;
            issue_done_r <= 1'b0;
            rd_pend_r    <= 1'b0;
            best_found_r <= 1'b0;
            free_found_r <= 1'b0;
          end
        end
        S_SCAN_A, S_SCAN_B: begin
          rd_pend_r <= !issue_done_r;
          rd_idx_r  <= addr_r;
          if (!issue_done_r) begin
            if (sweep_last) issue_done_r <= 1'b1;
            else            addr_r       <= addr_r + AW'(1);
          end
          if (take_best) begin
            best_found_r <= 1'b1;
            best_idx_r   <= rd_idx_r;
            best_id_r    <= rd_id;
            best_prio_r  <= rd_prio;
            best_stamp_r <= rd_stamp;
          end
          if (take_free) begin
            free_found_r <= 1'b1;
            free_idx_r   <= rd_idx_r;
          end
        end
        S_WRITE: begin
          status_r <= wr_status;
          popped_r <= pop_ok ? best_id_r : '0;
          if (ins_ok) begin
            stamp_ctr_r <= stamp_ctr_r + 32'd1;
            count_r     <= count_r + CW'(1);
          end else if (pop_ok) begin
            count_r <= count_r - CW'(1);
          end
          // restart for the front scan
          addr_r       <= '0;
          issue_done_r <= 1'b0;
          rd_pend_r    <= 1'b0;
          best_found_r <= 1'b0;
        end
        S_CLEAR: begin
          addr_r   <= sweep_last ? '0 : addr_r + AW'(1);
          count_r  <= '0;
          status_r <= STATUS_OK;
          popped_r <= '0;
        end
        default: begin
          rd_pend_r <= 1'b0;
        end
      endcase
    end
  end

  // result register, loaded once the front scan or the clearing pass is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_tvalid_r <= 1'b1;
      out_tuser_r  <= status_r;
      out_tdata_r  <= {COUNT_OUT_W'(count_r),
                       count_r == '0,
                       best_found_r ? IN_PRIO_W'(best_prio_r) : 8'd0,
                       best_found_r ? best_id_r : 16'd0,
                       popped_r};
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // occupancy never goes past the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count above table depth");

  // an insert into a full table finds no free slot and reports full
  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) && (kind_r == KIND_INSERT) && (count_r == FULL_COUNT)
    |=> status_r == STATUS_FULL)
    else $error("insert into full table not reported");

  // the front scan finds an entry exactly when the table is not empty
  a_front_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (best_found_r == (count_r != '0)))
    else $error("front entry disagrees with entry count");

  // scans only read the slot memory
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN_A) || (state_r == S_SCAN_B)) |-> !ram_we)
    else $error("slot write during scan");

endmodule

/* tb/stable_min_priority_queue_unit_tb.sv */
`timescale 1ns / 1ps

module stable_min_priority_queue_unit_tb;
  import smpq_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int OPS_TARGET  = 1750;
  // covers the slowest honest run of roughly 1750 words plus long holds
  localparam int CYCLE_LIMIT = 1_500_000;
  // receiver hold-off long enough for the block to fill up and block its input
  localparam int LONG_HOLD   = 800;
  // settle time after the last result
  localparam int SETTLE      = 2 * DEPTH + 40;

  // one expected result word
  typedef struct {
    status_t     status;
    logic [15:0] popped_id;
    logic [15:0] front_id;
    logic [7:0]  front_prio;
    logic        is_empty;
    logic [6:0]  entry_count;
  } queue_outcome_t;

  // mixes of operations for a stretch of random words
  typedef enum {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } op_mix_t;

  // mirror of the slot table plus the list of results still owed by the block
  class queue_outcome_board;
    bit             used [DEPTH];
    logic [15:0]    key  [DEPTH];
    logic [7:0]     rank [DEPTH];
    logic [31:0]    seq  [DEPTH];
    logic [31:0]    arrival_seq;
    int unsigned    live;
    int unsigned    errors;
    queue_outcome_t pending_outcomes[$];

    function new();
      arrival_seq = '0;
      live        = 0;
      errors      = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    // lowest priority wins, then the older stamp, then the lower slot
    function int most_urgent(bit by_id, logic [15:0] id);
      int best = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (used[i] && (!by_id || key[i] == id)) begin
          if (best < 0 || rank[i] < rank[best] ||
              (rank[i] == rank[best] && seq[i] < seq[best]))
            best = i;
        end
      end
      return best;
    endfunction

    // apply one accepted operation and queue the result it must produce
    function void take_op(kind_t kind, logic [15:0] id, logic [7:0] prio);
      queue_outcome_t o;
      int slot;
      o.status    = STATUS_OK;
      o.popped_id = '0;
      case (kind)
        KIND_INSERT: begin
          slot = -1;
          for (int i = 0; i < DEPTH; i++) begin
            if (!used[i]) begin
              slot = i;
              break;
            end
          end
          if (slot < 0) begin
            o.status = STATUS_FULL;
          end else begin
            arrival_seq = arrival_seq + 32'd1;
            used[slot]  = 1'b1;
            key[slot]   = id;
            rank[slot]  = prio;
            seq[slot]   = arrival_seq;
            live++;
          end
        end
        KIND_POP: begin
          slot = most_urgent(1'b0, '0);
          if (slot < 0) begin
            o.status = STATUS_EMPTY;
          end else begin
            o.popped_id = key[slot];
            used[slot]  = 1'b0;
            live--;
          end
        end
        KIND_UPGRADE: begin
          slot = most_urgent(1'b1, id);
          if (slot < 0)
            o.status = STATUS_NOT_FOUND;
          else if (rank[slot] <= prio)
            o.status = STATUS_NOT_MORE_URGENT;
          else
            rank[slot] = prio;
        end
        default: begin
          foreach (used[i]) used[i] = 1'b0;
          live = 0;
        end
      endcase
      slot          = most_urgent(1'b0, '0);
      o.front_id    = (slot < 0) ? 16'd0 : key[slot];
      o.front_prio  = (slot < 0) ? 8'd0 : rank[slot];
      o.is_empty    = (live == 0);
      o.entry_count = 7'(live);
      pending_outcomes.push_back(o);
    endfunction

    function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_outcome(logic [2:0] status_bits, logic [47:0] data);
      queue_outcome_t o;
      if (pending_outcomes.size() == 0) begin
        $error("result word with no operation waiting: status %0h data %0h",
               status_bits, data);
        errors++;
        return;
      end
      o = pending_outcomes.pop_front();
      field_check("status",      o.status,      status_bits);
      field_check("popped_id",   o.popped_id,   data[15:0]);
      field_check("front_id",    o.front_id,    data[31:16]);
      field_check("front_prio",  o.front_prio,  data[39:32]);
      field_check("is_empty",    o.is_empty,    data[40]);
      field_check("entry_count", o.entry_count, data[47:41]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // entry_id[15:0], prio_value[23:16]
  logic [1:0]  in_tuser;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // popped_id, front_id, front_prio, is_empty, entry_count
  logic [2:0]  out_tuser;  // status[2:0]

  queue_outcome_board board = new();

  // shared knobs between the stimulus and the receiver
  bit          use_gaps = 1'b1;   // per-word random idling on both sides
  bit          hold_req = 1'b0;   // asks the receiver for one long hold-off
  int unsigned ops_sent = 0;
  int unsigned cycles   = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stable_min_priority_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // offer one word, holding it until the block takes it
  task automatic send_op(kind_t kind, logic [15:0] id, logic [7:0] prio);
    int gap;
    gap = use_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {prio, id};
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    board.take_op(kind, id, prio);
    ops_sent++;
  endtask

  // stop offering until every owed result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // ids mostly from a small pool so upgrades find matches and duplicates occur
  function automatic logic [15:0] draw_id();
    return ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 15)) : 16'($urandom());
  endfunction

  // priorities mostly small so ties on priority are common
  function automatic logic [7:0] draw_prio();
    return ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 15)) : 8'($urandom());
  endfunction

  function automatic kind_t draw_kind(op_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return KIND_CLEAR;
    case (mix)
      MIX_FILL:  return (r < 80) ? KIND_INSERT : (r < 90) ? KIND_POP : KIND_UPGRADE;
      MIX_DRAIN: return (r < 25) ? KIND_INSERT : (r < 75) ? KIND_POP : KIND_UPGRADE;
      default:   return (r < 45) ? KIND_INSERT : (r < 70) ? KIND_POP : KIND_UPGRADE;
    endcase
  endfunction

  // result side: random stall per word, plus one long hold-off when asked
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin : receive_loop
      int stall;
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = use_gaps ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  // every accepted result word is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_outcome(out_tuser, out_tdata);
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    op_mix_t mix;
    int      run_len;
    bit      hold_done;
    hold_done = 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_INSERT;
    rst_n     <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: operations on an empty table
    send_op(KIND_POP,     16'h0000, 8'h00);
    send_op(KIND_UPGRADE, 16'h0005, 8'h01);
    send_op(KIND_CLEAR,   16'hffff, 8'hff);
    // field extremes, equal priorities resolved by arrival order
    send_op(KIND_INSERT,  16'h0000, 8'hff);
    send_op(KIND_INSERT,  16'hffff, 8'h00);
    send_op(KIND_INSERT,  16'h1234, 8'h00);
    // equal priority is not an upgrade; a real upgrade keeps its old stamp
    send_op(KIND_UPGRADE, 16'h0000, 8'hff);
    send_op(KIND_UPGRADE, 16'h0000, 8'h00);
    send_op(KIND_UPGRADE, 16'h0007, 8'h00);
    // duplicate id: the more urgent of the two is the upgrade target
    send_op(KIND_INSERT,  16'h0000, 8'h80);
    send_op(KIND_UPGRADE, 16'h0000, 8'h40);
    send_op(KIND_POP,     16'h0000, 8'h00);
    send_op(KIND_POP,     16'h0000, 8'h00);
    send_op(KIND_POP,     16'h0000, 8'h00);
    send_op(KIND_UPGRADE, 16'h0000, 8'h10);
    send_op(KIND_POP,     16'h0000, 8'h00);
    send_op(KIND_POP,     16'h0000, 8'h00);
    // clear with entries present, then the stamps keep counting
    send_op(KIND_INSERT,  16'haaaa, 8'h55);
    send_op(KIND_INSERT,  16'h5555, 8'haa);
    send_op(KIND_CLEAR,   16'h0000, 8'h00);
    send_op(KIND_UPGRADE, 16'haaaa, 8'h00);
    send_op(KIND_INSERT,  16'h0101, 8'h7f);
    send_op(KIND_INSERT,  16'h0202, 8'h7f);
    send_op(KIND_POP,     16'h0000, 8'h00);
    wait_drained();

    // random stretches with different mixes; fill stretches run into the full table
    while (ops_sent < OPS_TARGET) begin
      mix      = op_mix_t'($urandom_range(0, 2));
      use_gaps = ($urandom_range(0, 3) != 0);
      run_len  = $urandom_range(40, 120);
      if (!hold_done && ops_sent > 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      repeat (run_len) send_op(draw_kind(mix), draw_id(), draw_prio());
      if ($urandom_range(0, 2) == 0)
        wait_drained();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
design/smpq_pkg.sv
design/smpq_ram.sv
design/smpq_cmp.sv
design/stable_min_priority_queue_unit.sv
tb/stable_min_priority_queue_unit_tb.sv
